// ===== rtl/mpfde_pkg.sv =====
// ----------------------------------------------------------------------------
// mpfde_pkg
// shared types and constants of the page framebuffer draw engine
// ----------------------------------------------------------------------------
package mpfde_pkg;

   localparam int STRIDE_DEF        = 88;
   localparam int ROWS_DEF          = 48;
   localparam int VISIBLE_WIDTH_DEF = 84;

   localparam logic [2:0] MODE_CLEAR  = 3'd0;
   localparam logic [2:0] MODE_PIXEL  = 3'd1;
   localparam logic [2:0] MODE_HLINE  = 3'd2;
   localparam logic [2:0] MODE_VLINE  = 3'd3;
   localparam logic [2:0] MODE_RECT   = 3'd4;
   localparam logic [2:0] MODE_FILL   = 3'd5;
   localparam logic [2:0] MODE_READ   = 3'd6;
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   // job kinds handed from front to back
   localparam logic [1:0] JOB_NONE  = 2'd0;
   localparam logic [1:0] JOB_CLEAR = 2'd1;
   localparam logic [1:0] JOB_DRAW  = 2'd2;
   localparam logic [1:0] JOB_READ  = 2'd3;

   typedef struct packed {
      logic [2:0] mode;
      logic [6:0] x;
      logic [5:0] y;
      logic [6:0] width;
      logic [5:0] height;
      logic       color;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       status;
   } rsp_type;

   // classified job: a column range times a row range, or clear, or read
   typedef struct packed {
      logic [1:0] kind;
      logic       outline;
      logic       skip;
      logic [6:0] x0;
      logic [6:0] x1;
      logic [5:0] y0;
      logic [5:0] y1;
      logic       color;
   } job_type;

endpackage

// ===== rtl/mpfde_front.sv =====
// ----------------------------------------------------------------------------
// mpfde_front
// takes a command, checks bounds and turns it into a rectangular job
// ----------------------------------------------------------------------------
module mpfde_front #(
   parameter int STRIDE        = mpfde_pkg::STRIDE_DEF,
   parameter int ROWS          = mpfde_pkg::ROWS_DEF,
   parameter int VISIBLE_WIDTH = mpfde_pkg::VISIBLE_WIDTH_DEF
) (
   input  mpfde_pkg::req_type req,
   output mpfde_pkg::job_type job
);
   logic [7:0] xe;
   logic [6:0] ye;
   logic       xs_out, ys_out;
   logic       empty;

   always_comb begin
      xe     = {1'b0, req.x} + {1'b0, req.width};
      ye     = {1'b0, req.y} + {1'b0, req.height};
      xs_out = ({1'b0, req.x} >= 8'(STRIDE));
      ys_out = ({1'b0, req.y} >= 7'(ROWS));
      empty  = 1'b0;
      job         = '0;
      job.color   = req.color;
      job.x0      = req.x;
      job.x1      = req.x;
      job.y0      = req.y;
      job.y1      = req.y;
      job.kind    = mpfde_pkg::JOB_DRAW;
      unique case (req.mode)
         mpfde_pkg::MODE_CLEAR: job.kind = mpfde_pkg::JOB_CLEAR;
         mpfde_pkg::MODE_PIXEL: job.skip = xs_out | ys_out;
         mpfde_pkg::MODE_HLINE: begin
            job.skip = ys_out | (xe > 8'(STRIDE));
            job.x1   = 7'(xe - 8'd1);
            empty    = (req.width == '0);
         end
         mpfde_pkg::MODE_VLINE: begin
            job.skip = xs_out | (ye > 7'(ROWS));
            job.y1   = 6'(ye - 7'd1);
            empty    = (req.height == '0);
         end
         mpfde_pkg::MODE_RECT, mpfde_pkg::MODE_FILL: begin
            job.skip    = (xe > 8'(VISIBLE_WIDTH)) | (ye > 7'(ROWS));
            job.x1      = 7'(xe - 8'd1);
            job.y1      = 6'(ye - 7'd1);
            job.outline = (req.mode == mpfde_pkg::MODE_RECT);
            empty       = (req.width == '0) | (req.height == '0);
         end
         mpfde_pkg::MODE_READ: begin
            job.kind = mpfde_pkg::JOB_READ;
            job.skip = xs_out | ys_out;
         end
         default: job.skip = 1'b1;
      endcase
      if (job.kind == mpfde_pkg::JOB_DRAW && (job.skip || empty))
         job.kind = mpfde_pkg::JOB_NONE;
   end
endmodule

// ===== rtl/mpfde_back.sv =====
// ----------------------------------------------------------------------------
// mpfde_back
// executes jobs: walks columns and pages with read-modify-write, or clears or reads the store
// ----------------------------------------------------------------------------
module mpfde_back #(
   parameter int STRIDE = mpfde_pkg::STRIDE_DEF,
   parameter int ROWS   = mpfde_pkg::ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  mpfde_pkg::job_type job,
   output logic               job_ready,
   output logic               rsp_valid,
   output mpfde_pkg::rsp_type rsp
);
   localparam int PAGES = (ROWS + 7) / 8;
   localparam int DEPTH = STRIDE * PAGES;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RD    = 3'd2;
   localparam logic [2:0] ST_WR    = 3'd3;
   localparam logic [2:0] ST_RDATA = 3'd4;
   localparam logic [2:0] ST_CLR   = 3'd5;

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [6:0]          col_ff, col_in;
   logic [2:0]          page_ff, page_in;
   mpfde_pkg::job_type  job_ff, job_in;
   logic                rv_ff, rv_in;
   mpfde_pkg::rsp_type  rsp_ff, rsp_in;

   logic [AW-1:0] cur_addr;
   logic [7:0]    mask;
   logic [7:0]    wdata;
   logic          we;
   logic [2:0]    plo, phi;
   logic          edge_col, last_col, last_page;
   logic [5:0]    rlo;

   assign job_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      cur_addr = AW'(32'(page_ff) * STRIDE + 32'(col_ff));
      plo      = job_ff.y0[5:3];
      phi      = job_ff.y1[5:3];
      edge_col = (col_ff == job_ff.x0) || (col_ff == job_ff.x1);
      // outline: inner columns only get top and bottom rows
      mask = '0;
      for (int b = 0; b < 8; b++) begin
         rlo = {page_ff, 3'(b)};
         if (rlo >= job_ff.y0 && rlo <= job_ff.y1) begin
            if (!job_ff.outline || edge_col || rlo == job_ff.y0 || rlo == job_ff.y1)
               mask[b] = 1'b1;
         end
      end
      wdata     = job_ff.color ? (rdata_ff | mask) : (rdata_ff & ~mask);
      last_col  = (col_ff == job_ff.x1);
      last_page = (page_ff == phi);
      we        = (state_ff == ST_WR) || (state_ff == ST_CLR) || (state_ff == ST_INIT);
   end

   always_ff @(posedge clock) begin
      if (we)
         mem[addr_ff] <= (state_ff == ST_WR) ? wdata : 8'd0;
      rdata_ff <= mem[addr_in];
   end

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      col_in   = col_ff;
      page_in  = page_ff;
      job_in   = job_ff;
      rv_in    = 1'b0;
      rsp_in   = '0;
      unique case (state_ff)
         ST_INIT, ST_CLR: begin
            addr_in = addr_ff + AW'(1);
            if (addr_ff == AW'(DEPTH - 1)) begin
               addr_in  = '0;
               state_in = ST_IDLE;
               rv_in    = (state_ff == ST_CLR);
            end
         end
         ST_IDLE: begin
            if (job_valid) begin
               job_in  = job;
               col_in  = job.x0;
               page_in = job.y0[5:3];
               addr_in = AW'(32'(job.y0[5:3]) * STRIDE + 32'(job.x0));
               unique case (job.kind)
                  mpfde_pkg::JOB_CLEAR: begin
                     addr_in  = '0;
                     state_in = ST_CLR;
                  end
                  mpfde_pkg::JOB_DRAW: state_in = ST_RD;
                  mpfde_pkg::JOB_READ: begin
                     if (job.skip) begin
                        rv_in         = 1'b1;
                        rsp_in.status = 1'b1;
                     end else
                        state_in = ST_RDATA;
                  end
                  default: begin
                     rv_in         = 1'b1;
                     rsp_in.status = job.skip;
                  end
               endcase
            end
         end
         ST_RD: begin
            addr_in  = cur_addr;
            state_in = ST_WR;
         end
         ST_WR: begin
            // next byte: pages within a column, then next column
            state_in = ST_RD;
            if (!last_page) begin
               page_in = page_ff + 3'd1;
               addr_in = AW'(32'(page_ff + 3'd1) * STRIDE + 32'(col_ff));
            end else if (!last_col) begin
               page_in = plo;
               col_in  = col_ff + 7'd1;
               addr_in = AW'(32'(plo) * STRIDE + 32'(col_ff + 7'd1));
            end else begin
               state_in = ST_IDLE;
               rv_in    = 1'b1;
            end
         end
         ST_RDATA: begin
            state_in         = ST_IDLE;
            rv_in            = 1'b1;
            rsp_in.read_data = rdata_ff;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         addr_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         rv_ff    <= rv_in;
      end
      col_ff  <= col_in;
      page_ff <= page_in;
      job_ff  <= job_in;
      rsp_ff  <= rsp_in;
   end
endmodule

// ===== rtl/mpfde_queue.sv =====
// ----------------------------------------------------------------------------
// mpfde_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module mpfde_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mpfde_pkg::job_type push_job,
   output logic               full,
   output logic               pop_valid,
   output mpfde_pkg::job_type pop_job,
   input  logic               pop
);
   mpfde_pkg::job_type ent_ff [2];
   logic [1:0] cnt_ff;
   logic       rp_ff, wp_ff;

   assign full      = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_job   = ent_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) ent_ff[wp_ff] <= push_job;
      if (reset) begin
         cnt_ff <= '0;
         rp_ff  <= 1'b0;
         wp_ff  <= 1'b0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

// ===== rtl/mono_page_framebuffer_draw_engine.sv =====
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_engine
// monochrome page framebuffer with pixel, line, rectangle, clear and read
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy low; each command gives one
// rsp_valid strobe, which cannot be held off. Commands go into a two-entry
// queue and busy is high only while that queue holds two jobs. Drawing does a
// read-modify-write per touched byte (one store port), a read state then a
// write state; a clear sweeps the whole store and a read fetches one byte.
// A job can wait in the queue behind earlier ones. After reset the store is
// swept to zero; commands may still be queued then, up to two before busy
// rises.
module mono_page_framebuffer_draw_engine #(
   parameter int STRIDE        = mpfde_pkg::STRIDE_DEF,
   parameter int ROWS          = mpfde_pkg::ROWS_DEF,
   parameter int VISIBLE_WIDTH = mpfde_pkg::VISIBLE_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  mpfde_pkg::req_type req_data,
   output logic               rsp_valid,
   output mpfde_pkg::rsp_type rsp_data
);
   mpfde_pkg::job_type fjob, qjob;
   logic full, qv, bready;

   mpfde_front #(.STRIDE(STRIDE), .ROWS(ROWS), .VISIBLE_WIDTH(VISIBLE_WIDTH)) u_front (
      .req(req_data), .job(fjob)
   );

   mpfde_queue u_queue (
      .clock(clock), .reset(reset), .push(start && !busy), .push_job(fjob),
      .full(full), .pop_valid(qv), .pop_job(qjob), .pop(qv && bready)
   );

   mpfde_back #(.STRIDE(STRIDE), .ROWS(ROWS)) u_back (
      .clock(clock), .reset(reset), .job_valid(qv), .job(qjob), .job_ready(bready),
      .rsp_valid(rsp_valid), .rsp(rsp_data)
   );

   assign busy = full;
endmodule

// ===== rtl/mpfde_checker.sv =====
// ----------------------------------------------------------------------------
// mpfde_checker
// port-level checks of the draw engine
// ----------------------------------------------------------------------------
module mpfde_checker (
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_valid,
   input mpfde_pkg::rsp_type rsp_data
);
   a_no_rsp_in_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("strobe right after reset");
   a_skip_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (rsp_data.read_data == 8'd0))
      else $error("skipped beat carries data");
   a_busy_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(busy))
      else $error("busy unknown");
endmodule

bind mono_page_framebuffer_draw_engine mpfde_checker u_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
